FILE: hw/rtl/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types, register codes and character constants for the space run to
// tab converter.
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int COLUMN_BITS_DEF = 16;
  localparam int MAX_STOPS       = 4;
  localparam int NUM_STOP_REGS   = 4;
  localparam int BYTE_W          = 8;
  localparam int HELD_W          = 16;
  localparam int STOP_W          = 16;
  localparam int CFG_DATA_W      = 16;
  localparam int CFG_INDEX_W     = 3;
  localparam int RES_DEPTH       = 3;

  localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB      = 8'h09;
  localparam logic [BYTE_W-1:0] CH_BS       = 8'h08;
  localparam logic [BYTE_W-1:0] CH_NL       = 8'h0A;
  localparam logic [7:0]        DEFAULT_TAB = 8'd8;

  localparam logic [2:0] LIST_LIMIT =
    3'((MAX_STOPS < NUM_STOP_REGS) ? MAX_STOPS : NUM_STOP_REGS);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TAB_SIZE,
    REG_CONVERT_ALL,
    REG_STOP_COUNT,
    REG_STOP_A,
    REG_STOP_B,
    REG_STOP_C,
    REG_STOP_D
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]                           tab_size;
    logic                                 convert_all;
    logic [2:0]                           stop_count;
    logic [NUM_STOP_REGS-1:0][STOP_W-1:0] stops;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic apply;
    logic advance;
  } stc_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic res_none;
    logic res_last;
  } stc_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_APPLY,
    ST_EMIT
  } stc_state_t;

endpackage

FILE: hw/rtl/stc_cfg_regs.sv
// ----------------------------------------------------------------------------
// stc_cfg_regs
// Configuration register file: tab size, convert mode and explicit stop list.
// ----------------------------------------------------------------------------
module stc_cfg_regs
  import stc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tab_size    <= DEFAULT_TAB;
      cfg.convert_all <= 1'b0;
      cfg.stop_count  <= '0;
      cfg.stops       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TAB_SIZE:    cfg.tab_size    <= cfg_wdata[7:0];
        REG_CONVERT_ALL: cfg.convert_all <= cfg_wdata[0];
        REG_STOP_COUNT:  cfg.stop_count  <= cfg_wdata[2:0];
        REG_STOP_A:      cfg.stops[0]    <= cfg_wdata[STOP_W-1:0];
        REG_STOP_B:      cfg.stops[1]    <= cfg_wdata[STOP_W-1:0];
        REG_STOP_C:      cfg.stops[2]    <= cfg_wdata[STOP_W-1:0];
        REG_STOP_D:      cfg.stops[3]    <= cfg_wdata[STOP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/stc_datapath.sv
// ----------------------------------------------------------------------------
// stc_datapath
// Line state, serial remainder unit for tab stops, per-byte update logic and
// the small result buffer that feeds the output port.
// ----------------------------------------------------------------------------
module stc_datapath
  import stc_pkg::*;
#(
  parameter int COLUMN_BITS = COLUMN_BITS_DEF
)
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic [BYTE_W-1:0]  in_byte,
  input  logic               end_of_input,
  input  stc_cmd_t           cmd,
  output stc_status_t        status,
  output logic [BYTE_W-1:0]  out_byte,
  output logic [HELD_W-1:0]  repeat_res,
  output logic               run_last
);

  localparam int CNT_W = $clog2(COLUMN_BITS + 1);
  localparam int WIDE  = (COLUMN_BITS > STOP_W) ? COLUMN_BITS : STOP_W;
  localparam logic [WIDE-1:0] COL_MAX_W = WIDE'({COLUMN_BITS{1'b1}});

  // line state
  logic [COLUMN_BITS-1:0] column, column_next;
  logic [COLUMN_BITS-1:0] next_stop, next_stop_next;
  logic                   past_last_stop, past_last_stop_next;
  logic                   converting, converting_next;
  logic                   previous_blank, previous_blank_next;
  logic                   single_blank, single_blank_next;
  logic [HELD_W-1:0]      held_count, held_count_next;
  logic                   held_first_tab, held_first_tab_next;

  // request latch
  logic [BYTE_W-1:0] byte_q;
  logic              eoi_q;

  // remainder unit
  logic [7:0]             rem, rem_next;
  logic [COLUMN_BITS-1:0] dvd;
  logic [CNT_W-1:0]       cnt;
  logic [8:0]             trial;

  // result buffer
  logic [BYTE_W-1:0] res_byte [RES_DEPTH];
  logic [HELD_W-1:0] res_rep  [RES_DEPTH];
  logic [BYTE_W-1:0] res_byte_next [RES_DEPTH];
  logic [HELD_W-1:0] res_rep_next  [RES_DEPTH];
  logic [1:0]        res_n, res_n_next;
  logic [1:0]        res_idx;

  // stop candidates
  logic [COLUMN_BITS-1:0] col_inc;
  logic [COLUMN_BITS:0]   tab_sum;
  logic [COLUMN_BITS-1:0] tab_stop;
  logic [7:0]             tab_gap;
  logic [COLUMN_BITS:0]   div_sum;
  logic [COLUMN_BITS-1:0] div_stop;
  logic [COLUMN_BITS-1:0] list_stop;
  logic                   list_past;
  logic [2:0]             lim;
  logic                   blank_in;

  assign col_inc  = (column == '1) ? column : column + 1'b1;
  assign tab_sum  = {1'b0, column} + (COLUMN_BITS+1)'(cfg.tab_size);
  assign tab_stop = tab_sum[COLUMN_BITS] ? '1 : tab_sum[COLUMN_BITS-1:0];
  assign tab_gap  = cfg.tab_size - rem;
  assign div_sum  = {1'b0, column} + (COLUMN_BITS+1)'(tab_gap);
  assign div_stop = div_sum[COLUMN_BITS] ? '1 : div_sum[COLUMN_BITS-1:0];
  assign lim      = (cfg.stop_count > LIST_LIMIT) ? LIST_LIMIT : cfg.stop_count;

  always_comb begin
    list_past = 1'b1;
    list_stop = col_inc;
    for (int i = NUM_STOP_REGS - 1; i >= 0; i--) begin
      if (3'(i) < lim && WIDE'(cfg.stops[i]) > WIDE'(column)) begin
        list_past = 1'b0;
        list_stop = (WIDE'(cfg.stops[i]) > COL_MAX_W) ? '1
                                                       : COLUMN_BITS'(cfg.stops[i]);
      end
    end
  end

  assign blank_in = (in_byte == CH_SPACE) || (in_byte == CH_TAB);

  assign trial    = {rem, dvd[COLUMN_BITS-1]};
  assign rem_next = (trial >= {1'b0, cfg.tab_size}) ? 8'(trial - {1'b0, cfg.tab_size})
                                                    : trial[7:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_q <= in_byte;
      eoi_q  <= end_of_input;
      dvd    <= column;
      rem    <= '0;
      cnt    <= CNT_W'(COLUMN_BITS);
    end else if (cmd.div_step) begin
      dvd <= {dvd[COLUMN_BITS-2:0], 1'b0};
      rem <= rem_next;
      cnt <= cnt - 1'b1;
    end
  end

  // per-byte update
  always_comb begin
    logic       blank;
    logic       hold;
    logic       emit_tab;
    logic       do_flush;
    logic       emit_char;
    logic       line_reset;
    logic       first_tab;
    logic [1:0] n;

    column_next         = column;
    next_stop_next      = next_stop;
    past_last_stop_next = past_last_stop;
    converting_next     = converting;
    previous_blank_next = previous_blank;
    single_blank_next   = single_blank;
    held_count_next     = held_count;
    held_first_tab_next = held_first_tab;
    blank      = (byte_q == CH_SPACE) || (byte_q == CH_TAB);
    hold       = 1'b0;
    emit_tab   = 1'b0;
    do_flush   = 1'b0;
    emit_char  = 1'b0;
    line_reset = 1'b0;
    n          = '0;
    for (int i = 0; i < RES_DEPTH; i++) begin
      res_byte_next[i] = res_byte[i];
      res_rep_next[i]  = res_rep[i];
    end

    if (eoi_q) begin
      do_flush   = converting;
      line_reset = 1'b1;
    end else begin
      if (converting) begin
        if (blank) begin
          if (column >= next_stop) begin
            if (cfg.tab_size != '0 && column == next_stop) begin
              next_stop_next      = tab_stop;
              past_last_stop_next = 1'b0;
            end else if (cfg.tab_size != '0) begin
              next_stop_next      = div_stop;
              past_last_stop_next = 1'b0;
            end else begin
              next_stop_next      = list_stop;
              past_last_stop_next = list_past;
            end
          end
          if (past_last_stop_next) converting_next = 1'b0;
          if (converting_next) begin
            if (byte_q == CH_TAB) begin
              column_next = next_stop_next;
              if (held_count != '0) held_first_tab_next = 1'b1;
              held_count_next = single_blank ? HELD_W'(1) : '0;
            end else begin
              column_next = col_inc;
              if (!(previous_blank && col_inc == next_stop_next)) begin
                hold = 1'b1;
                if (col_inc == next_stop_next) single_blank_next = 1'b1;
                if (held_count == '0) held_first_tab_next = 1'b0;
                if (held_count != '1) held_count_next = held_count + 1'b1;
                previous_blank_next = 1'b1;
              end else begin
                emit_tab            = 1'b1;
                held_first_tab_next = 1'b1;
                held_count_next     = single_blank ? HELD_W'(1) : '0;
              end
            end
          end
        end else if (byte_q == CH_BS) begin
          if (column != '0) column_next = column - 1'b1;
          next_stop_next = '0;
        end else if (byte_q != CH_NL) begin
          column_next = col_inc;
        end
        if (!hold) begin
          do_flush            = 1'b1;
          previous_blank_next = blank;
          converting_next     = converting_next && (cfg.convert_all || blank);
        end
      end
      if (!hold) begin
        if (byte_q == CH_NL) begin
          emit_char  = 1'b1;
          line_reset = 1'b1;
        end else if (!emit_tab) begin
          emit_char = 1'b1;
        end
      end
    end

    // result slots in emission order
    if (emit_tab) begin
      res_byte_next[n] = CH_TAB;
      res_rep_next[n]  = HELD_W'(1);
      n = n + 1'b1;
    end
    first_tab = held_first_tab_next || (held_count_next > HELD_W'(1) && single_blank_next);
    if (do_flush && held_count_next != '0) begin
      res_byte_next[n] = first_tab ? CH_TAB : CH_SPACE;
      res_rep_next[n]  = HELD_W'(1);
      n = n + 1'b1;
    end
    if (do_flush && held_count_next > HELD_W'(1)) begin
      res_byte_next[n] = CH_SPACE;
      res_rep_next[n]  = held_count_next - 1'b1;
      n = n + 1'b1;
    end
    if (do_flush) begin
      held_count_next     = '0;
      held_first_tab_next = 1'b0;
      single_blank_next   = 1'b0;
    end
    if (emit_char && n != 2'd3) begin
      res_byte_next[n] = byte_q;
      res_rep_next[n]  = HELD_W'(1);
      n = n + 1'b1;
    end
    res_n_next = n;

    if (line_reset) begin
      column_next         = '0;
      next_stop_next      = '0;
      past_last_stop_next = 1'b0;
      converting_next     = 1'b1;
      previous_blank_next = 1'b1;
      single_blank_next   = 1'b0;
      held_count_next     = '0;
      held_first_tab_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column         <= '0;
      next_stop      <= '0;
      past_last_stop <= 1'b0;
      converting     <= 1'b1;
      previous_blank <= 1'b1;
      single_blank   <= 1'b0;
      held_count     <= '0;
      held_first_tab <= 1'b0;
      res_n          <= '0;
      res_idx        <= '0;
    end else if (cmd.apply) begin
      column         <= column_next;
      next_stop      <= next_stop_next;
      past_last_stop <= past_last_stop_next;
      converting     <= converting_next;
      previous_blank <= previous_blank_next;
      single_blank   <= single_blank_next;
      held_count     <= held_count_next;
      held_first_tab <= held_first_tab_next;
      res_n          <= res_n_next;
      res_idx        <= '0;
    end else if (cmd.advance) begin
      res_idx <= res_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      for (int i = 0; i < RES_DEPTH; i++) begin
        res_byte[i] <= res_byte_next[i];
        res_rep[i]  <= res_rep_next[i];
      end
    end
  end

  assign status.need_div = !end_of_input && converting && blank_in &&
                           (column > next_stop) && (cfg.tab_size != '0);
  assign status.div_last = (cnt == CNT_W'(1));
  assign status.res_none = (res_n_next == '0);
  assign status.res_last = (res_idx == res_n - 1'b1);

  assign out_byte   = res_byte[res_idx];
  assign repeat_res = res_rep[res_idx];
  assign run_last   = status.res_last;

endmodule

FILE: hw/rtl/stc_ctrl.sv
// ----------------------------------------------------------------------------
// stc_ctrl
// Sequencer: accepts a request, runs the remainder unit when a tab stop must
// be found, applies the update and hands out the buffered results.
// ----------------------------------------------------------------------------
module stc_ctrl
  import stc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  stc_status_t status,
  output stc_cmd_t    cmd
);

  stc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.need_div ? ST_DIV : ST_APPLY;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = status.res_none ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (status.res_last) begin
            in_stall = 1'b0;
            if (in_valid) begin
              cmd.load   = 1'b1;
              state_next = status.need_div ? ST_DIV : ST_APPLY;
            end else begin
              state_next = ST_IDLE;
            end
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/space_run_to_tab_converter_top.sv
// ----------------------------------------------------------------------------
// space_run_to_tab_converter_top
// Turns runs of blanks in a byte stream into tabs, one byte per request.
//
//   channel   direction  handshake             payload
//   config    in         cfg_we                cfg_index, cfg_wdata
//   input     in         in_valid / in_stall   in_byte, end_of_input
//   output    out        out_valid / out_stall out_byte, repeat_res, run_last
//
// a request passes an accept state, the serial remainder unit when a blank
// must find a uniform tab stop, and an update state,
// then 0 to 3 results, one per cycle while out_stall is low
// a new request is taken in the cycle the last result is taken
// rst is synchronous; after it the tab size is 8 and the line state is clear
// ----------------------------------------------------------------------------
module space_run_to_tab_converter_top
  import stc_pkg::*;
#(
  parameter int COLUMN_BITS = COLUMN_BITS_DEF
)
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [BYTE_W-1:0]      in_byte,
  input  logic                   end_of_input,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [BYTE_W-1:0]      out_byte,
  output logic [HELD_W-1:0]      repeat_res,
  output logic                   run_last
);

  cfg_t        cfg;
  stc_cmd_t    cmd;
  stc_status_t status;

  stc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  stc_datapath #(
    .COLUMN_BITS (COLUMN_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .cmd          (cmd),
    .status       (status),
    .out_byte     (out_byte),
    .repeat_res   (repeat_res),
    .run_last     (run_last)
  );

  stc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

endmodule

FILE: hw/rtl/stc_checker.sv
// ----------------------------------------------------------------------------
// stc_checker
// Port-level checks for the space run to tab converter, bound to the top.
// ----------------------------------------------------------------------------
module stc_checker
  import stc_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [BYTE_W-1:0]      out_byte,
  input logic [HELD_W-1:0]      repeat_res,
  input logic                   run_last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
                               $stable(repeat_res) && $stable(run_last))
    else $error("stalled result changed");

  // a fresh request never shows a stale result next cycle
  a_no_stale: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid)
    else $error("result shown right after request");

  // no new request while results of the current one are pending
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !run_last |-> in_stall)
    else $error("request taken before last result");

  // every result repeats at least once
  a_repeat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> repeat_res != '0)
    else $error("zero repeat count");

endmodule

bind space_run_to_tab_converter_top stc_checker u_stc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_byte   (out_byte),
  .repeat_res (repeat_res),
  .run_last   (run_last)
);
